// ----- rtl/core/lbg_pkg.sv -----
// ----------------------------------------------------------------------------
// lbg_pkg
// Shared constants and helpers for the line pixel generator.
// ----------------------------------------------------------------------------
package lbg_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOUR_W       = 32;
    localparam int MAX_RESULTS    = 64;
    localparam int QUEUE_DEPTH    = 2;

    // classified command: six coordinates/deltas, two step signs, error, colour
    function automatic int rec_width(input int cw);
        return 7 * cw + 4 + COLOUR_W;
    endfunction

endpackage

// ----- rtl/core/lbg_if.sv -----
// ----------------------------------------------------------------------------
// lbg interfaces
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface lbg_cmd_if #(
    parameter int CW = lbg_pkg::COORD_BITS_DEF
);
    import lbg_pkg::*;

    logic                valid;
    logic                ready;
    logic [CW-1:0]       start_x;
    logic [CW-1:0]       start_y;
    logic [CW-1:0]       end_x;
    logic [CW-1:0]       end_y;
    logic [COLOUR_W-1:0] colour;

    modport source (output valid, start_x, start_y, end_x, end_y, colour, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface lbg_pix_if #(
    parameter int CW = lbg_pkg::COORD_BITS_DEF
);
    import lbg_pkg::*;

    logic                valid;
    logic                ready;
    logic [CW-1:0]       pixel_x;
    logic [CW-1:0]       pixel_y;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_colour, last_pixel, output ready);
endinterface

// ----- rtl/core/line_pixel_generator.sv -----
// First pixel path: command queue, then line registers, then output register.
// Throughput: one pixel per cycle within a line while the output is not stalled; the stepper
// loads each line, then steps once per pixel, up to 64 pixels per line.
// The two-entry command queue accepts further commands while a line is drawn.
// Zero-length lines are dropped at the front and never reach the queue or the stepper.
// Reset: synchronous, active low; clears queue, stepper and output valid.
// ----------------------------------------------------------------------------
// line_pixel_generator
// Top level: command front, command queue and Bresenham pixel stepper.
// ----------------------------------------------------------------------------
module line_pixel_generator #(
    parameter int COORD_BITS = lbg_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbg_cmd_if.sink   i_cmd,
    lbg_pix_if.source o_pix
);
    import lbg_pkg::*;

    localparam int REC_W = rec_width(COORD_BITS);

    logic             push;
    logic             push_ready;
    logic [REC_W-1:0] push_rec;
    logic             pop_valid;
    logic             pop;
    logic [REC_W-1:0] pop_rec;

    lbg_front #(.CW(COORD_BITS)) u_front (
        .i_cmd        (i_cmd),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_rec        (push_rec)
    );

    lbg_queue #(.W(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       (push_rec),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_data       (pop_rec)
    );

    lbg_back #(.CW(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop       (pop),
        .i_rec       (pop_rec),
        .o_pix       (o_pix)
    );

endmodule

// ----- rtl/core/lbg_front.sv -----
// ----------------------------------------------------------------------------
// lbg_front
// Accepts line commands, works out deltas, step directions and the initial
// error term, and drops zero-length lines.
// ----------------------------------------------------------------------------
module lbg_front #(
    parameter int CW = lbg_pkg::COORD_BITS_DEF
) (
    lbg_cmd_if.sink                        i_cmd,
    output logic                           o_push,
    input  logic                           i_push_ready,
    output logic [lbg_pkg::rec_width(CW)-1:0] o_rec
);
    import lbg_pkg::*;

    logic [CW-1:0]        adx;
    logic [CW-1:0]        ady;
    logic                 xneg;
    logic                 yneg;
    logic signed [CW+1:0] err0;
    logic                 nonzero;

    always_comb begin
        xneg = !(i_cmd.start_x < i_cmd.end_x);
        yneg = !(i_cmd.start_y < i_cmd.end_y);
        adx  = xneg ? i_cmd.start_x - i_cmd.end_x : i_cmd.end_x - i_cmd.start_x;
        ady  = yneg ? i_cmd.start_y - i_cmd.end_y : i_cmd.end_y - i_cmd.start_y;
        if (adx > ady) begin
            err0 = $signed({3'b000, adx[CW-1:1]});
        end else begin
            err0 = -$signed({3'b000, ady[CW-1:1]});
        end
        nonzero = (i_cmd.start_x != i_cmd.end_x) || (i_cmd.start_y != i_cmd.end_y);
    end

    assign i_cmd.ready = i_push_ready;
    assign o_push      = i_cmd.valid && nonzero;
    assign o_rec       = {i_cmd.start_x, i_cmd.start_y, i_cmd.end_x, i_cmd.end_y,
                          adx, ady, xneg, yneg, err0, i_cmd.colour};

endmodule

// ----- rtl/core/lbg_queue.sv -----
// ----------------------------------------------------------------------------
// lbg_queue
// Short first-in first-out queue between command front and pixel stepper.
// ----------------------------------------------------------------------------
module lbg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = lbg_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_push_ready,
    input  logic [W-1:0] i_data,
    output logic         o_pop_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_data       = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/lbg_back.sv -----
// ----------------------------------------------------------------------------
// lbg_back
// Bresenham stepper: loads a classified line and emits one pixel per cycle
// into an output register while that register is not stalled.
// ----------------------------------------------------------------------------
module lbg_back #(
    parameter int CW = lbg_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pop_valid,
    output logic                              o_pop,
    input  logic [lbg_pkg::rec_width(CW)-1:0] i_rec,
    lbg_pix_if.source                         o_pix
);
    import lbg_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    logic [CW-1:0]        q_cx, q_cy, q_tx, q_ty, q_adx, q_ady;
    logic                 q_xneg, q_yneg;
    logic signed [CW+1:0] q_err;
    logic [COLOUR_W-1:0]  q_colour;

    logic                 r_busy;
    logic [CW-1:0]        r_cx, r_cy, r_tx, r_ty, r_adx, r_ady;
    logic                 r_xneg, r_yneg;
    logic signed [CW+1:0] r_err;
    logic [COLOUR_W-1:0]  r_colour;
    logic [CNT_W-1:0]     r_cnt;

    logic                 r_ovalid;
    logic [CW-1:0]        r_ox, r_oy;
    logic [COLOUR_W-1:0]  r_ocolour;
    logic                 r_olast;

    logic                 emit;
    logic                 step_x, step_y;
    logic signed [CW+1:0] adx_s, ady_s;
    logic [CW-1:0]        n_cx, n_cy;
    logic signed [CW+1:0] n_err;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_last;

    assign {q_cx, q_cy, q_tx, q_ty, q_adx, q_ady, q_xneg, q_yneg, q_err, q_colour} = i_rec;

    assign emit  = r_busy && (!r_ovalid || o_pix.ready);
    assign o_pop = !r_busy && i_pop_valid;

    always_comb begin
        adx_s  = $signed({2'b00, r_adx});
        ady_s  = $signed({2'b00, r_ady});
        step_x = (r_err > -adx_s) && (r_cx != r_tx);
        step_y = (r_err < ady_s) && (r_cy != r_ty);
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_err  = r_err;
        if (step_x) begin
            n_cx  = r_xneg ? r_cx - 1'b1 : r_cx + 1'b1;
            n_err = n_err - ady_s;
        end
        if (step_y) begin
            n_cy  = r_yneg ? r_cy - 1'b1 : r_cy + 1'b1;
            n_err = n_err + adx_s;
        end
        n_cnt  = r_cnt + 1'b1;
        n_last = ((n_cx == r_tx) && (n_cy == r_ty)) || !(step_x || step_y) ||
                 (n_cnt == CNT_W'(MAX_RESULTS));
    end

    // line registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cx     <= q_cx;
            r_cy     <= q_cy;
            r_tx     <= q_tx;
            r_ty     <= q_ty;
            r_adx    <= q_adx;
            r_ady    <= q_ady;
            r_xneg   <= q_xneg;
            r_yneg   <= q_yneg;
            r_err    <= q_err;
            r_colour <= q_colour;
            r_cnt    <= '0;
        end else if (emit) begin
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_err <= n_err;
            r_cnt <= n_cnt;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ox      <= r_cx;
            r_oy      <= r_cy;
            r_ocolour <= r_colour;
            r_olast   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_pix.valid        = r_ovalid;
    assign o_pix.pixel_x      = r_ox;
    assign o_pix.pixel_y      = r_oy;
    assign o_pix.pixel_colour = r_ocolour;
    assign o_pix.last_pixel   = r_olast;

endmodule

// ----- rtl/core/lbg_checker.sv -----
// ----------------------------------------------------------------------------
// lbg_checker
// Port-level assertions for the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module lbg_checker #(
    parameter int CW = lbg_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [CW-1:0]                i_pixel_x,
    input logic [CW-1:0]                i_pixel_y,
    input logic [lbg_pkg::COLOUR_W-1:0] i_pixel_colour,
    input logic                         i_last_pixel
);
    import lbg_pkg::*;

    // output is idle straight after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("pixel valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("pixel valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_pixel_x) && $stable(i_pixel_y) &&
                                $stable(i_pixel_colour) && $stable(i_last_pixel))
        else $error("pixel payload changed while stalled");

    // within a line the next pixel follows at once with the same colour
    a_line_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last_pixel |=> i_valid && $stable(i_pixel_colour))
        else $error("line broken after a non-final transfer");

endmodule

bind line_pixel_generator lbg_checker #(.CW(COORD_BITS)) u_lbg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_pix.valid),
    .i_ready        (o_pix.ready),
    .i_pixel_x      (o_pix.pixel_x),
    .i_pixel_y      (o_pix.pixel_y),
    .i_pixel_colour (o_pix.pixel_colour),
    .i_last_pixel   (o_pix.last_pixel)
);
